[sv/hcsp_pkg.sv]
// Package for the host command stream parser.
// Holds the opcode codes, frame lengths, status and reply codes and the queue record.
// No dependencies.
package hcsp_pkg;

  localparam int HIGHEST_OPCODE = 13;
  localparam int CMD_KEEP       = 9;
  localparam int DISCARD_CAP    = 10;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic [7:0] MIN_LINK_RST = 8'd2;
  localparam logic [7:0] MAX_LINK_RST = 8'd71;

  localparam logic [7:0] OP_NOP = 8'd0;
  localparam logic [7:0] OP_RTS = 8'd1;
  localparam logic [7:0] OP_STR = 8'd2;
  localparam logic [7:0] OP_CLS = 8'd3;
  localparam logic [7:0] OP_ALL = 8'd4;
  localparam logic [7:0] OP_GVB = 8'd5;
  localparam logic [7:0] OP_RET = 8'd6;
  localparam logic [7:0] OP_INR = 8'd7;
  localparam logic [7:0] OP_INS = 8'd8;
  localparam logic [7:0] OP_ECO = 8'd9;
  localparam logic [7:0] OP_ERP = 8'd10;
  localparam logic [7:0] OP_ERR = 8'd11;
  localparam logic [7:0] OP_RST = 8'd12;
  localparam logic [7:0] OP_RRP = 8'd13;

  localparam logic [0:0] CFG_MIN_LINK = 1'd0;
  localparam logic [0:0] CFG_MAX_LINK = 1'd1;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_BAD_PARAM = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_ILLEGAL   = 3'd4,
    ST_SHORT     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RP_NONE = 2'd0,
    RP_CLS  = 2'd1,
    RP_ERP  = 2'd2,
    RP_RRP  = 2'd3
  } reply_t;

  typedef enum logic [1:0] {
    RK_COMMAND,
    RK_ILLEGAL,
    RK_SHORT
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t                     kind;
    logic [7:0]                    opcode;
    logic [3:0]                    err_len;
    logic [CMD_KEEP-1:0][7:0]      bytes;
  } rec_t;

  typedef struct packed {
    logic [7:0]  opcode;
    status_t     status;
    reply_t      reply;
    logic [31:0] foreign_socket;
    logic [31:0] local_socket;
    logic [7:0]  link_or_size;
    logic [15:0] word_one;
    logic [15:0] word_two;
    logic [15:0] word_three;
    logic [3:0]  error_length;
  } result_t;

  function automatic logic [3:0] frame_len(input logic [7:0] op);
    logic [3:0] len;
    len = 4'd1;
    unique case (op)
      OP_RTS, OP_STR:                 len = 4'd10;
      OP_CLS:                         len = 4'd9;
      OP_ALL, OP_RET:                 len = 4'd8;
      OP_GVB:                         len = 4'd4;
      OP_INR, OP_INS, OP_ECO, OP_ERP: len = 4'd2;
      OP_ERR:                         len = 4'd12;
      default:                        len = 4'd1;
    endcase
    return len;
  endfunction

endpackage

[sv/host_command_stream_parser.sv]
// Host command stream parser, top level.
// Joins the framer, the record queue and the checker. Uses hcsp_pkg.
//
// Input channel: one command-area byte per beat (in_data_byte), with
// in_last_byte marking the final byte of a message. A beat is taken when
// in_valid is high and in_stall is low.
// Output channel: one result beat per framed command or framing error,
// held in an output register until out_valid is seen with out_stall low.
// Configuration: cfg_we writes cfg_wdata to min_link (index 0) or max_link
// (index 1); write only while the block is idle.
// Throughput: one byte per cycle while out_stall is low. The framer takes
// a byte every cycle while the two-entry record queue has room; the
// checker drains one record per cycle into the output register while
// it is empty or out_stall is low. A completing byte's record is written
// to the queue, and its result is then loaded into the output register.
// Reset: rst_n low (synchronous) clears framing position, queue and output
// valid, and loads min_link 2 and max_link 71.
// Receiver stall: the output register holds; the queue fills, then in_stall
// rises until a result is taken.
module host_command_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_opcode,
  output logic [2:0]  out_status,
  output logic [1:0]  out_reply,
  output logic [31:0] out_foreign_socket,
  output logic [31:0] out_local_socket,
  output logic [7:0]  out_link_or_size,
  output logic [15:0] out_word_one,
  output logic [15:0] out_word_two,
  output logic [15:0] out_word_three,
  output logic [3:0]  out_error_length,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import hcsp_pkg::*;

  logic    push, pop, full, head_valid;
  rec_t    push_rec, head_rec;
  result_t res;

  assign in_stall = full;

  hcsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_rec     (push_rec)
  );

  hcsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  hcsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_opcode         = res.opcode;
  assign out_status         = res.status;
  assign out_reply          = res.reply;
  assign out_foreign_socket = res.foreign_socket;
  assign out_local_socket   = res.local_socket;
  assign out_link_or_size   = res.link_or_size;
  assign out_word_one       = res.word_one;
  assign out_word_two       = res.word_two;
  assign out_word_three     = res.word_three;
  assign out_error_length   = res.error_length;

endmodule

[sv/hcsp_front.sv]
// Framer: takes command-area bytes and frames commands by opcode length.
// Pushes one record per finished command or error into the queue. Uses hcsp_pkg.
module hcsp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          push,
  output hcsp_pkg::rec_t push_rec
);
  import hcsp_pkg::*;

  logic [3:0]               pos_r, pos_nxt;
  logic [7:0]               op_r, op_nxt;
  logic                     disc_r, disc_nxt;
  logic [CMD_KEEP-1:0][7:0] cmd_r, cmd_nxt;
  logic                     accept;
  logic [7:0]               op_eff;
  logic [3:0]               idx;

  assign accept = in_valid && !in_stall;
  assign idx    = pos_r - 4'd1;

  always_comb begin
    pos_nxt  = pos_r;
    op_nxt   = op_r;
    disc_nxt = disc_r;
    cmd_nxt  = cmd_r;
    push     = 1'b0;
    op_eff   = (pos_r == 4'd0) ? in_data_byte : op_r;
    push_rec.kind    = RK_COMMAND;
    push_rec.opcode  = op_eff;
    push_rec.err_len = 4'd0;
    push_rec.bytes   = cmd_r;
    if (accept) begin
      if (disc_r) begin
        if (pos_r < 4'(DISCARD_CAP)) begin
          pos_nxt = pos_r + 4'd1;
        end
        if (in_last_byte) begin
          push             = 1'b1;
          push_rec.kind    = RK_ILLEGAL;
          push_rec.opcode  = op_r;
          push_rec.err_len = pos_nxt;
          disc_nxt         = 1'b0;
          pos_nxt          = 4'd0;
        end
      end else if (pos_r == 4'd0 && in_data_byte > 8'(HIGHEST_OPCODE)) begin
        op_nxt = in_data_byte;
        if (in_last_byte) begin
          push             = 1'b1;
          push_rec.kind    = RK_ILLEGAL;
          push_rec.err_len = 4'd1;
        end else begin
          disc_nxt = 1'b1;
          pos_nxt  = 4'd1;
        end
      end else begin
        if (pos_r == 4'd0) begin
          op_nxt = in_data_byte;
        end else if (pos_r <= 4'(CMD_KEEP)) begin
          cmd_nxt[idx] = in_data_byte;
        end
        push_rec.bytes = cmd_nxt;
        if (pos_r + 4'd1 >= frame_len(op_eff)) begin
          push    = 1'b1;
          pos_nxt = 4'd0;
        end else if (in_last_byte) begin
          push             = 1'b1;
          push_rec.kind    = RK_SHORT;
          push_rec.err_len = pos_r + 4'd1;
          pos_nxt          = 4'd0;
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 4'd0;
      op_r   <= OP_NOP;
      disc_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      op_r   <= op_nxt;
      disc_r <= disc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

[sv/hcsp_queue.sv]
// Short record queue between the framer and the checker.
// Register storage read at the head pointer. Uses hcsp_pkg.
module hcsp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hcsp_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output hcsp_pkg::rec_t head_rec
);
  import hcsp_pkg::*;

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("push lost");
`endif

endmodule

[sv/hcsp_back.sv]
// Checker: decodes queued records into results and holds them in the output register.
// Holds the link bound registers. Uses hcsp_pkg.
module hcsp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              head_valid,
  input  hcsp_pkg::rec_t    head_rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output hcsp_pkg::result_t out_res
);
  import hcsp_pkg::*;

  logic [7:0] min_link_r, max_link_r;
  logic       valid_r, valid_nxt;
  result_t    res_r, res_nxt;
  logic       pol_bad, dir_bad, link_bad, hi_nz;
  logic [7:0] lb, op;

  assign pop       = head_valid && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign op        = head_rec.opcode;
  assign lb        = head_rec.bytes[8];
  assign hi_nz     = (head_rec.bytes[4] | head_rec.bytes[5]) != 8'd0;
  assign pol_bad   = !(head_rec.bytes[3][0] ^ head_rec.bytes[7][0]);
  assign dir_bad   = !(head_rec.bytes[3][0] ^ op[0]);
  assign link_bad  = (op == OP_RTS) && (lb < min_link_r || lb > max_link_r);

  always_comb begin
    res_nxt = '0;
    res_nxt.opcode = op;
    res_nxt.status = ST_ACCEPTED;
    res_nxt.reply  = RP_NONE;
    unique case (head_rec.kind)
      RK_ILLEGAL: begin
        res_nxt.status       = ST_ILLEGAL;
        res_nxt.error_length = head_rec.err_len;
      end
      RK_SHORT: begin
        res_nxt.status       = ST_SHORT;
        res_nxt.error_length = head_rec.err_len;
      end
      default: begin
        unique case (op)
          OP_RTS, OP_STR, OP_CLS: begin
            res_nxt.foreign_socket = {head_rec.bytes[0], head_rec.bytes[1],
                                      head_rec.bytes[2], head_rec.bytes[3]};
            res_nxt.local_socket   = {head_rec.bytes[4], head_rec.bytes[5],
                                      head_rec.bytes[6], head_rec.bytes[7]};
            if (op == OP_CLS) begin
              if (pol_bad) begin
                res_nxt.status = ST_BAD_PARAM;
              end else if (hi_nz) begin
                res_nxt.status = ST_UNMATCHED;
              end
            end else begin
              res_nxt.link_or_size = lb;
              if (pol_bad || dir_bad || link_bad) begin
                res_nxt.status = ST_BAD_PARAM;
              end else if ((op == OP_STR && lb[2:0] != 3'd0) || hi_nz) begin
                res_nxt.status = ST_REFUSED;
                res_nxt.reply  = RP_CLS;
              end
            end
          end
          OP_ALL: begin
            res_nxt.link_or_size = head_rec.bytes[0];
            res_nxt.word_one     = {head_rec.bytes[1], head_rec.bytes[2]};
            res_nxt.word_two     = {head_rec.bytes[3], head_rec.bytes[4]};
            res_nxt.word_three   = {head_rec.bytes[5], head_rec.bytes[6]};
          end
          OP_ECO: begin
            res_nxt.link_or_size = head_rec.bytes[0];
            res_nxt.reply        = RP_ERP;
          end
          OP_RST: begin
            res_nxt.reply = RP_RRP;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      min_link_r <= MIN_LINK_RST;
      max_link_r <= MAX_LINK_RST;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we && cfg_index == CFG_MIN_LINK) begin
        min_link_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_MAX_LINK) begin
        max_link_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |-> !pop)
    else $error("result overwritten while stalled");
  a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped record not presented");
  a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.status != ST_ILLEGAL && res_r.status != ST_SHORT
      |-> res_r.error_length == 4'd0)
    else $error("error length on a non-error result");
`endif

endmodule
